// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the tag bit registry.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, switched off while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/tbr_pkg.sv =====
// Package of shared widths, codes and defaults for the tag bit registry.
package tbr_pkg;

    localparam int TAG_W         = 32;
    localparam int MASK_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int TAG_SLOTS_DEF = 32;

    typedef enum logic [0:0] {
        CMD_REGISTER = 1'b0,
        CMD_LOOKUP   = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

endpackage

// ===== sv/tag_bit_registry_top.sv =====
// Tag bit registry: accepts one request per cycle; the tag is compared against every occupied
// slot in parallel in the same cycle and the answer lands in a result register, so with the
// consumer ready a request is taken every clock and its result appears on the following one.
// The parallel tag compare across all slots in the same cycle sets that figure. A register request
// always answers; a lookup answers only on the request flagged last. No clearing pass is
// needed after reset: only slots below the fill count are ever compared.
`include "assert_macros.svh"

module tag_bit_registry_top #(
    parameter int TAG_SLOTS = tbr_pkg::TAG_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tbr_pkg::TAG_W-1:0]     tag,
    input  logic [tbr_pkg::MASK_W-1:0]    mask_in,
    input  logic                          last,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tbr_pkg::MASK_W-1:0]    mask,
    output logic [tbr_pkg::STATUS_W-1:0]  status
);

    localparam int CNT_W  = $clog2(TAG_SLOTS + 1);
    localparam int SLOT_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

    // Tag store and fill count
    logic [tbr_pkg::TAG_W-1:0]   store_reg [TAG_SLOTS];
    logic [CNT_W-1:0]            tags_used_reg, tags_used_next;
    logic [TAG_SLOTS-1:0]        list_mask_reg, list_mask_next;
    logic                        list_missed_reg, list_missed_next;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic [tbr_pkg::MASK_W-1:0]  mask_reg, mask_next;
    tbr_pkg::status_t            status_reg, status_next;

    logic                        in_fire;
    logic                        out_fire;
    logic [TAG_SLOTS-1:0]        match_vec;
    logic                        hit;
    logic                        full;
    logic [TAG_SLOTS-1:0]        new_bit;
    logic                        store_wr;
    tbr_pkg::command_t           cmd;

    assign cmd      = tbr_pkg::command_t'(command);
    assign out_fire = out_valid_reg && out_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Parallel compare over occupied slots; tags are distinct so the hit vector has at most one bit set
    always_comb
    begin
        for (int i = 0; i < TAG_SLOTS; i++)
        begin
            match_vec[i] = (CNT_W'(i) < tags_used_reg) && (store_reg[i] == tag);
        end
    end

    assign hit     = |match_vec;
    assign full    = (tags_used_reg == CNT_W'(TAG_SLOTS));
    assign new_bit = {{(TAG_SLOTS-1){1'b0}}, 1'b1} << tags_used_reg;

    // Next state and result
    always_comb
    begin
        tags_used_next   = tags_used_reg;
        list_mask_next   = list_mask_reg;
        list_missed_next = list_missed_reg;
        store_wr         = 1'b0;
        out_valid_next   = out_fire ? 1'b0 : out_valid_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        if (in_fire)
        begin
            unique case (cmd)
                tbr_pkg::CMD_REGISTER:
                begin
                    out_valid_next = 1'b1;
                    priority if (hit)
                    begin
                        mask_next   = mask_in | tbr_pkg::MASK_W'(match_vec);
                        status_next = tbr_pkg::STATUS_OK;
                    end
                    else if (!full)
                    begin
                        store_wr       = 1'b1;
                        tags_used_next = tags_used_reg + CNT_W'(1);
                        mask_next      = mask_in | tbr_pkg::MASK_W'(new_bit);
                        status_next    = tbr_pkg::STATUS_OK;
                    end
                    else
                    begin
                        mask_next   = mask_in;
                        status_next = tbr_pkg::STATUS_FULL;
                    end
                end
                tbr_pkg::CMD_LOOKUP:
                begin
                    if (last)
                    begin
                        out_valid_next   = 1'b1;
                        list_mask_next   = '0;
                        list_missed_next = 1'b0;
                        if (list_missed_reg || !hit)
                        begin
                            mask_next   = '0;
                            status_next = tbr_pkg::STATUS_UNKNOWN;
                        end
                        else
                        begin
                            mask_next   = tbr_pkg::MASK_W'(list_mask_reg | match_vec);
                            status_next = tbr_pkg::STATUS_OK;
                        end
                    end
                    else
                    begin
                        list_mask_next   = list_mask_reg | match_vec;
                        list_missed_next = list_missed_reg || !hit;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_used_reg   <= '0;
            list_mask_reg   <= '0;
            list_missed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tags_used_reg   <= tags_used_next;
            list_mask_reg   <= list_mask_next;
            list_missed_reg <= list_missed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers and tag store write
    always_ff @(posedge clk)
    begin
        mask_reg   <= mask_next;
        status_reg <= status_next;
        if (store_wr)
        begin
            store_reg[tags_used_reg[SLOT_W-1:0]] <= tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign mask      = mask_reg;
    assign status    = status_reg;

    // Checks
    `ASSERT_CLK(a_count_bound, clk, rst_n, tags_used_reg <= CNT_W'(TAG_SLOTS),
                "fill count overflow")
    `ASSERT_CLK(a_count_step, clk, rst_n,
                (tags_used_reg == $past(tags_used_reg)) ||
                (tags_used_reg == $past(tags_used_reg) + CNT_W'(1)),
                "fill count jumped")
    `ASSERT_IMPL(a_reg_answers, clk, rst_n, in_fire && (cmd == tbr_pkg::CMD_REGISTER),
                 ##1 out_valid_reg, "register request gave no result")
    `ASSERT_IMPL(a_full_status, clk, rst_n,
                 out_valid_reg && (status_reg == tbr_pkg::STATUS_FULL), full,
                 "full status with free slots")

endmodule
